// File: rtl/blrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded list with remove-all-matching.
package blrm_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 64;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_REMOVE     = 2'd2,
		REQ_READ       = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_REMOVE
	} fsm_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic signed [63:0] value;
		logic [3:0]         read_index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [4:0]         removed_count;
		logic [4:0]         list_length;
		logic signed [63:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic shl;
		logic shr;
	} cell_ctl_t;

endpackage

// File: rtl/blrm_cell.sv
`timescale 1ns / 1ps
// One list cell: holds an entry, loads from the bus or from either neighbor.
module blrm_cell #(
	parameter int DATA_WIDTH = blrm_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  blrm_pkg::cell_ctl_t   ctl,
	input  logic                  wr,
	input  logic [DATA_WIDTH-1:0] bus,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			data_q <= bus;
		end else if (ctl.shr) begin
			data_q <= left;
		end else if (ctl.shl) begin
			data_q <= right;
		end
	end

	assign data = data_q;

endmodule

// File: rtl/bounded_list_remove_all_matching.sv
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed values kept in a row of shifting cells.
// Push front, push back and read are answered at once: the request beat is
// taken and its result beat is registered on the same edge. Remove-all-matching
// on a list of L entries visits each entry once after the request beat: the entries
// rotate through the head cell one per cycle, the head is compared with the
// key, and kept entries are written back at the tail, so order is preserved.
// No request beat is taken while a remove is running or while a result beat
// is held stalled. Read index reaches the first 16 positions.
module bounded_list_remove_all_matching #(
	parameter int DEPTH      = blrm_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = blrm_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  blrm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output blrm_pkg::rsp_t rsp
);

	localparam int LW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int RD_N = (DEPTH < 16) ? DEPTH : 16;

	blrm_pkg::fsm_t      state_q, state_d;
	logic [LW-1:0]       len_q, len_d;
	logic [LW-1:0]       steps_q, steps_d;
	logic [LW-1:0]       rmcnt_q, rmcnt_d;
	logic [DATA_WIDTH-1:0] key_q, key_d;
	logic                rsp_valid_q, rsp_valid_d;
	blrm_pkg::rsp_t      rsp_q, rsp_d;

	blrm_pkg::cell_ctl_t ctl;
	logic                wr_en;
	logic [IW-1:0]       wr_idx;
	logic [DATA_WIDTH-1:0] bus;
	logic [DATA_WIDTH-1:0] cell_d [DEPTH];
	logic [DEPTH-1:0]    cell_wr;
	logic [DATA_WIDTH-1:0] rd_raw;
	logic [DATA_WIDTH-1:0] head;
	logic                hit;
	logic                full;
	logic                accept;

	assign req_stall = (state_q != blrm_pkg::FSM_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign head      = cell_d[0];
	assign hit       = (head == key_q);
	assign full      = (len_q >= LW'(DEPTH));

	always_comb begin
		rd_raw = '0;
		for (int k = 0; k < RD_N; k++) begin
			if (req.read_index == 4'(k)) begin
				rd_raw = cell_d[k];
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		steps_d     = steps_q;
		rmcnt_d     = rmcnt_q;
		key_d       = key_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		rsp_d       = rsp_q;
		ctl         = '0;
		wr_en       = 1'b0;
		wr_idx      = IW'(len_q);
		bus         = DATA_WIDTH'(req.value);
		case (state_q)
			blrm_pkg::FSM_IDLE: begin
				if (accept) begin
					rsp_d.status        = blrm_pkg::STS_OK;
					rsp_d.removed_count = '0;
					rsp_d.read_value    = '0;
					rsp_valid_d         = 1'b1;
					case (req.req_type)
						blrm_pkg::REQ_PUSH_FRONT: begin
							if (full) begin
								rsp_d.status = blrm_pkg::STS_FULL;
							end else begin
								ctl.shr = 1'b1;
								len_d   = len_q + LW'(1);
							end
						end
						blrm_pkg::REQ_PUSH_BACK: begin
							if (full) begin
								rsp_d.status = blrm_pkg::STS_FULL;
							end else begin
								wr_en = 1'b1;
								len_d = len_q + LW'(1);
							end
						end
						blrm_pkg::REQ_REMOVE: begin
							if (len_q == '0) begin
								rsp_d.status = blrm_pkg::STS_EMPTY;
							end else begin
								rsp_valid_d = 1'b0;
								state_d     = blrm_pkg::FSM_REMOVE;
								key_d       = DATA_WIDTH'(req.value);
								steps_d     = len_q;
								rmcnt_d     = '0;
							end
						end
						default: begin
							if ((LW + 4)'(req.read_index) >= (LW + 4)'(len_q)) begin
								rsp_d.status = blrm_pkg::STS_RANGE;
							end else begin
								rsp_d.read_value = 64'($signed(rd_raw));
							end
						end
					endcase
					rsp_d.list_length = 5'(len_d);
				end
			end
			blrm_pkg::FSM_REMOVE: begin
				ctl.shl = 1'b1;
				bus     = head;
				wr_idx  = IW'(len_q - LW'(1));
				if (hit) begin
					len_d   = len_q - LW'(1);
					rmcnt_d = rmcnt_q + LW'(1);
				end else begin
					wr_en = 1'b1;
				end
				steps_d = steps_q - LW'(1);
				if (steps_q == LW'(1)) begin
					state_d             = blrm_pkg::FSM_IDLE;
					rsp_valid_d         = 1'b1;
					rsp_d.status        = blrm_pkg::STS_OK;
					rsp_d.removed_count = 5'(rmcnt_d);
					rsp_d.list_length   = 5'(len_d);
					rsp_d.read_value    = '0;
				end
			end
			default: begin
				state_d = blrm_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= blrm_pkg::FSM_IDLE;
			len_q       <= '0;
			steps_q     <= '0;
			rmcnt_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			steps_q     <= steps_d;
			rmcnt_q     <= rmcnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		rsp_q <= rsp_d;
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		assign cell_wr[k] = wr_en && (wr_idx == IW'(k));
		blrm_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.wr   (cell_wr[k]),
			.bus  (bus),
			.left ((k == 0) ? bus : cell_d[(k == 0) ? 0 : k - 1]),
			.right((k == DEPTH - 1) ? cell_d[k] : cell_d[(k == DEPTH - 1) ? k : k + 1]),
			.data (cell_d[k])
		);
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: dv/bounded_list_remove_all_matching_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded list: directed and randomized push, remove and read traffic.
module bounded_list_remove_all_matching_tb;

	localparam int LIST_DEPTH = blrm_pkg::DEPTH_DEF;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 400;
	localparam int TAIL_WAIT  = 40;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	blrm_pkg::req_t  req       = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	blrm_pkg::rsp_t  rsp;

	blrm_pkg::req_t  pending[$];
	blrm_pkg::rsp_t  list_expect[$];

	logic signed [63:0] model_list [LIST_DEPTH];
	int    model_len = 0;

	int    sent;
	int    gap_left;
	int    rsp_seen;
	int    errors = 0;
	int    wait_left;
	int    hold_left;
	logic  hold_done;

	bounded_list_remove_all_matching DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	function automatic blrm_pkg::rsp_t list_apply(input blrm_pkg::req_t r);
		blrm_pkg::rsp_t o;
		int   i;
		int   w;
		int   removed;
		o = '0;
		o.status = blrm_pkg::STS_OK;
		removed = 0;
		case (r.req_type)
			blrm_pkg::REQ_PUSH_FRONT: begin
				if (model_len >= LIST_DEPTH) begin
					o.status = blrm_pkg::STS_FULL;
				end else begin
					for (i = model_len; i > 0; i--)
						model_list[i] = model_list[i-1];
					model_list[0] = r.value;
					model_len++;
				end
			end
			blrm_pkg::REQ_PUSH_BACK: begin
				if (model_len >= LIST_DEPTH) begin
					o.status = blrm_pkg::STS_FULL;
				end else begin
					model_list[model_len] = r.value;
					model_len++;
				end
			end
			blrm_pkg::REQ_REMOVE: begin
				if (model_len == 0) begin
					o.status = blrm_pkg::STS_EMPTY;
				end else begin
					w = 0;
					for (i = 0; i < model_len; i++) begin
						if (model_list[i] == r.value)
							removed++;
						else begin
							model_list[w] = model_list[i];
							w++;
						end
					end
					model_len = w;
				end
			end
			default: begin
				if (r.read_index >= model_len)
					o.status = blrm_pkg::STS_RANGE;
				else
					o.read_value = model_list[r.read_index];
			end
		endcase
		o.removed_count = removed[4:0];
		o.list_length   = model_len[4:0];
		return o;
	endfunction

	// runs of zero wait every third period, random waits otherwise
	function automatic int pick_wait(input int n, input int period);
		if ((n / period) % 3 == 2)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic signed [63:0] draw_value();
		case ($urandom_range(0, 5))
			0: return 64'sh7fff_ffff_ffff_ffff;
			1: return 64'sh8000_0000_0000_0000;
			2: return 64'sd0;
			3: return -64'sd1;
			4: return 64'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_req(input blrm_pkg::req_kind_t k, input logic signed [63:0] v,
			input logic [3:0] idx);
		blrm_pkg::req_t r;
		r.req_type   = k;
		r.value      = v;
		r.read_index = idx;
		pending.push_back(r);
	endtask

	task automatic queue_directed();
		int i;
		queue_req(blrm_pkg::REQ_READ, 64'sd0, 4'd0);
		queue_req(blrm_pkg::REQ_REMOVE, 64'sd0, 4'd0);
		queue_req(blrm_pkg::REQ_PUSH_FRONT, 64'sh7fff_ffff_ffff_ffff, 4'd0);
		queue_req(blrm_pkg::REQ_PUSH_BACK, 64'sh8000_0000_0000_0000, 4'd0);
		queue_req(blrm_pkg::REQ_READ, 64'sd0, 4'd0);
		queue_req(blrm_pkg::REQ_READ, 64'sd0, 4'd1);
		queue_req(blrm_pkg::REQ_READ, 64'sd0, 4'd2);
		queue_req(blrm_pkg::REQ_REMOVE, 64'sd5, 4'd0);
		queue_req(blrm_pkg::REQ_REMOVE, 64'sh7fff_ffff_ffff_ffff, 4'd0);
		// last entry goes, list back to empty
		queue_req(blrm_pkg::REQ_REMOVE, 64'sh8000_0000_0000_0000, 4'd0);
		for (i = 0; i < LIST_DEPTH; i++)
			queue_req((i % 2) ? blrm_pkg::REQ_PUSH_BACK : blrm_pkg::REQ_PUSH_FRONT,
				(i % 4 == 0) ? -64'sd1 : 64'sd7, 4'd0);
		queue_req(blrm_pkg::REQ_PUSH_FRONT, 64'sd1, 4'd0);
		queue_req(blrm_pkg::REQ_PUSH_BACK, 64'sd1, 4'd0);
		queue_req(blrm_pkg::REQ_READ, 64'sd0, 4'd15);
		queue_req(blrm_pkg::REQ_REMOVE, 64'sd7, 4'd0);
		queue_req(blrm_pkg::REQ_REMOVE, -64'sd1, 4'd0);
	endtask

	// phases of fill, drain or mixed traffic over a small pool of keys
	task automatic queue_random(input int total);
		logic signed [63:0] pool [4];
		logic signed [63:0] v;
		int n;
		int phase;
		int pick;
		int k;
		int push_w;
		int rem_w;
		blrm_pkg::req_kind_t kind;
		n = 0;
		while (n < total) begin
			phase = $urandom_range(0, 3);
			for (k = 0; k < 4; k++)
				pool[k] = draw_value();
			push_w = (phase == 0) ? 80 : (phase == 1) ? 25 : 50;
			rem_w  = (phase == 0) ? 5  : (phase == 1) ? 45 : 20;
			repeat ($urandom_range(20, 60)) begin
				pick = $urandom_range(0, 99);
				if (pick < push_w)
					kind = blrm_pkg::req_kind_t'($urandom_range(0, 1));
				else if (pick < push_w + rem_w)
					kind = blrm_pkg::REQ_REMOVE;
				else
					kind = blrm_pkg::REQ_READ;
				v = ($urandom_range(0, 9) == 0) ? draw_value() : pool[2'($urandom_range(0, 3))];
				queue_req(kind, v, 4'($urandom_range(0, 15)));
				n++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left  <= 0;
			sent      <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				list_expect.push_back(list_apply(req));
				sent <= sent + 1;
				gap = pick_wait(sent, 90);
				if (gap == 0 && pending.size() != 0) begin
					req <= pending.pop_front();
				end else begin
					req_valid <= 1'b0;
					gap_left  <= gap;
				end
			end else if (!req_valid) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (pending.size() != 0) begin
					req       <= pending.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		blrm_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_seen <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			rsp_seen <= rsp_seen + 1;
			if (list_expect.size() == 0) begin
				if (errors < 10)
					$display("unexpected result beat: status %0d removed %0d len %0d value %0d",
						rsp.status, rsp.removed_count, rsp.list_length, rsp.read_value);
				errors = errors + 1;
			end else begin
				want = list_expect.pop_front();
				if (rsp.status !== want.status || rsp.removed_count !== want.removed_count ||
						rsp.list_length !== want.list_length ||
						rsp.read_value !== want.read_value) begin
					if (errors < 10) begin
						$display("mismatch at beat %0d", rsp_seen);
						$display("  expected: status %0d removed %0d len %0d value %0d",
							want.status, want.removed_count, want.list_length, want.read_value);
						$display("  actual:   status %0d removed %0d len %0d value %0d",
							rsp.status, rsp.removed_count, rsp.list_length, rsp.read_value);
					end
					errors = errors + 1;
				end
			end
		end
	end

	// one long hold-off on result beats so the block stalls its request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && rsp_seen == HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			wait_left <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			n = pick_wait(rsp_seen, 70);
			wait_left <= n;
			rsp_stall <= (n != 0) || (hold_left > 1);
		end else if (wait_left > 1) begin
			wait_left <= wait_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			wait_left <= 0;
			rsp_stall <= (hold_left > 1);
		end
	end

	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		queue_directed();
		queue_random(1350);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending.size() != 0 || req_valid || list_expect.size() != 0)
			@(negedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0 && list_expect.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
rtl/blrm_pkg.sv
rtl/blrm_cell.sv
rtl/bounded_list_remove_all_matching.sv
dv/bounded_list_remove_all_matching_tb.sv
